FILE: rtl/hbbse_pkg.sv
package hbbse_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_BIT    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] MODE_AFTER_NUL = 2'd0;
	localparam logic [1:0] MODE_STRIP_BOM = 2'd1;
	localparam logic [1:0] MODE_ISO_BITS  = 2'd2;
	localparam logic [1:0] MODE_FORM_BITS = 2'd3;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] result_value;
		logic       end_status;
		logic       last_result;
	} out_item_t;

	// one queue entry: an optional byte or bit, then an optional end status
	typedef struct packed {
		logic       prim_valid;
		logic [1:0] prim_kind;
		logic [7:0] prim_value;
		logic       stat_valid;
		logic       stat;
	} entry_t;

endpackage

FILE: rtl/hbbse_front.sv
module hbbse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  hbbse_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              push,
	output hbbse_pkg::entry_t push_entry
);
	import hbbse_pkg::*;

	localparam logic [7:0] BOM_0      = 8'hef;
	localparam logic [7:0] BOM_1      = 8'hbb;
	localparam logic [7:0] BOM_2      = 8'hbf;
	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_B       = 8'h42;
	localparam logic [7:0] CH_J       = 8'h4a;
	localparam logic [7:0] LEAD_LO    = 8'hf0;
	localparam logic [7:0] LEAD_HI    = 8'hf4;
	localparam logic [7:0] SEC_MIN_F0 = 8'h90;
	localparam logic [7:0] SEC_MAX_F4 = 8'h8f;
	localparam logic [7:0] SURR_LEAD  = 8'hed;
	localparam logic [7:0] HI_SURR_LO = 8'ha0;
	localparam logic [7:0] HI_SURR_HI = 8'haf;
	localparam logic [7:0] LO_SURR_LO = 8'hb0;
	localparam logic [7:0] LO_SURR_HI = 8'hbf;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	function automatic logic four_ok(input logic [7:0] b0, input logic [7:0] b1,
	                                 input logic [7:0] b2, input logic [7:0] b3);
		logic ok;
		ok = (b0 >= LEAD_LO) && (b0 <= LEAD_HI) && is_cont(b1) && is_cont(b2) && is_cont(b3);
		if (b0 == LEAD_LO && b1 < SEC_MIN_F0) ok = 1'b0;
		if (b0 == LEAD_HI && b1 > SEC_MAX_F4) ok = 1'b0;
		return ok;
	endfunction

	logic [1:0] mode_q;
	logic [7:0] look_q [5];
	logic [2:0] held_q;
	logic       nul_seen_q;
	logic [1:0] header_q;
	logic       mark_q;
	logic       any_bit_q;

	logic [7:0] look_n [5];
	logic [2:0] held_n;
	logic       nul_seen_n;
	logic [1:0] header_n;
	logic       mark_n;
	logic       any_bit_n;

	logic       accept;
	logic [7:0] c;
	logic       last;
	logic       status;
	logic [7:0] bom_byte;
	logic       iso_hit;

	logic [7:0] w [6];
	logic [2:0] cnt;
	logic       hit_a;
	logic       hit_p;
	logic       hit_b;
	logic       hit_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign c        = in_data.data_byte;
	assign last     = in_data.is_last;

	// candidate window for the form scan: held bytes with the new byte appended
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			if (i < 5 && 3'(i) < held_q) w[i] = look_q[i < 5 ? i : 0];
			else if (3'(i) == held_q)   w[i] = c;
			else                        w[i] = 8'h00;
		end
		cnt = held_q + 3'd1;
		hit_a = (cnt >= 3'd4) && four_ok(w[0], w[1], w[2], w[3]);
		hit_p = (cnt == 3'd6) && (w[0] == SURR_LEAD) && (w[1] >= HI_SURR_LO)
			&& (w[1] <= HI_SURR_HI) && is_cont(w[2]) && (w[3] == SURR_LEAD)
			&& (w[4] >= LO_SURR_LO) && (w[4] <= LO_SURR_HI) && is_cont(w[5]);
		hit_b = ((cnt == 3'd6) || (last && cnt == 3'd5)) && four_ok(w[1], w[2], w[3], w[4]);
		hit_d = last && (cnt == 3'd6) && four_ok(w[2], w[3], w[4], w[5]);
	end

	always_comb begin
		unique case (header_q)
			2'd0:    bom_byte = BOM_0;
			2'd1:    bom_byte = BOM_1;
			default: bom_byte = BOM_2;
		endcase
		iso_hit = (held_q >= 3'd2) && (look_q[0] == CH_ESC) && (look_q[1] == CH_LPAREN)
			&& ((c == CH_B) || (c == CH_J));
	end

	always_comb begin
		look_n     = look_q;
		held_n     = held_q;
		nul_seen_n = nul_seen_q;
		header_n   = header_q;
		mark_n     = mark_q;
		any_bit_n  = any_bit_q;
		push_entry = '0;
		status     = STATUS_NOT_FOUND;

		unique case (mode_q)
			MODE_AFTER_NUL: begin
				if (nul_seen_q) begin
					push_entry.prim_valid = 1'b1;
					push_entry.prim_kind  = KIND_DATA;
					push_entry.prim_value = c;
				end else if (c == 8'h00) begin
					nul_seen_n = 1'b1;
				end
				status = nul_seen_n ? STATUS_OK : STATUS_NOT_FOUND;
			end
			MODE_STRIP_BOM: begin
				if (mark_q) begin
					push_entry.prim_valid = 1'b1;
					push_entry.prim_kind  = KIND_DATA;
					push_entry.prim_value = c;
				end else if (header_q != 2'd3) begin
					if (c != bom_byte) begin
						header_n = 2'd3;
					end else if (header_q == 2'd2) begin
						header_n = 2'd3;
						mark_n   = 1'b1;
					end else begin
						header_n = header_q + 2'd1;
					end
				end
				status = mark_n ? STATUS_OK : STATUS_NOT_FOUND;
			end
			MODE_ISO_BITS: begin
				if (iso_hit) begin
					push_entry.prim_valid = 1'b1;
					push_entry.prim_kind  = KIND_BIT;
					push_entry.prim_value = {7'd0, c == CH_J};
					any_bit_n = 1'b1;
					held_n    = 3'd0;
				end else if (held_q >= 3'd2) begin
					look_n[0] = look_q[1];
					look_n[1] = c;
					held_n    = 3'd2;
				end else begin
					look_n[held_q] = c;
					held_n = held_q + 3'd1;
				end
				status = any_bit_n ? STATUS_OK : STATUS_NOT_FOUND;
			end
			MODE_FORM_BITS: begin
				if (hit_a || hit_p || hit_b || hit_d) begin
					push_entry.prim_valid = 1'b1;
					push_entry.prim_kind  = KIND_BIT;
					push_entry.prim_value = {7'd0, !hit_a && hit_p};
					any_bit_n = 1'b1;
				end
				// advance the window; at the last byte it is cleared below anyway
				if (hit_a) begin
					for (int i = 0; i < 5; i++) look_n[i] = 8'h00;
					look_n[0] = w[4];
					look_n[1] = w[5];
					held_n = cnt - 3'd4;
				end else if (hit_p) begin
					for (int i = 0; i < 5; i++) look_n[i] = 8'h00;
					held_n = 3'd0;
				end else if (cnt == 3'd6) begin
					if (hit_b) begin
						for (int i = 0; i < 5; i++) look_n[i] = (i == 0) ? w[5] : 8'h00;
						held_n = 3'd1;
					end else begin
						for (int i = 0; i < 5; i++) look_n[i] = w[i + 1];
						held_n = 3'd5;
					end
				end else begin
					for (int i = 0; i < 5; i++) look_n[i] = w[i];
					held_n = cnt;
				end
				status = any_bit_n ? STATUS_OK : STATUS_NOT_FOUND;
			end
			default: ;
		endcase

		if (last) begin
			push_entry.stat_valid = 1'b1;
			push_entry.stat       = status;
			for (int i = 0; i < 5; i++) look_n[i] = 8'h00;
			held_n     = 3'd0;
			nul_seen_n = 1'b0;
			header_n   = 2'd0;
			mark_n     = 1'b0;
			any_bit_n  = 1'b0;
		end
	end

	assign push = accept && (push_entry.prim_valid || push_entry.stat_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_AFTER_NUL;
			for (int i = 0; i < 5; i++) look_q[i] <= 8'h00;
			held_q     <= 3'd0;
			nul_seen_q <= 1'b0;
			header_q   <= 2'd0;
			mark_q     <= 1'b0;
			any_bit_q  <= 1'b0;
		end else if (cfg_we) begin
			// new mode: drop all stream state
			mode_q     <= cfg_wdata;
			for (int i = 0; i < 5; i++) look_q[i] <= 8'h00;
			held_q     <= 3'd0;
			nul_seen_q <= 1'b0;
			header_q   <= 2'd0;
			mark_q     <= 1'b0;
			any_bit_q  <= 1'b0;
		end else if (accept) begin
			look_q     <= look_n;
			held_q     <= held_n;
			nul_seen_q <= nul_seen_n;
			header_q   <= header_n;
			mark_q     <= mark_n;
			any_bit_q  <= any_bit_n;
		end
	end

endmodule

FILE: rtl/hbbse_queue.sv
module hbbse_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hbbse_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output hbbse_pkg::entry_t head
);
	import hbbse_pkg::*;

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/hbbse_back.sv
module hbbse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  hbbse_pkg::entry_t    q_head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hbbse_pkg::out_item_t out_data
);
	import hbbse_pkg::*;

	entry_t cur_q;
	logic   pend_prim_q;
	logic   pend_stat_q;
	logic   take;
	logic   finishing;

	assign out_valid = pend_prim_q || pend_stat_q;
	assign take      = out_valid && out_ready;
	assign finishing = take && !(pend_prim_q && pend_stat_q);
	assign pop       = !q_empty && (!out_valid || finishing);

	always_comb begin
		if (pend_prim_q) begin
			out_data.result_kind  = cur_q.prim_kind;
			out_data.result_value = cur_q.prim_value;
			out_data.end_status   = 1'b0;
			out_data.last_result  = !pend_stat_q;
		end else begin
			out_data.result_kind  = KIND_STATUS;
			out_data.result_value = 8'h00;
			out_data.end_status   = cur_q.stat;
			out_data.last_result  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_prim_q <= 1'b0;
			pend_stat_q <= 1'b0;
		end else if (pop) begin
			pend_prim_q <= q_head.prim_valid;
			pend_stat_q <= q_head.stat_valid;
		end else if (take) begin
			// hand out the byte or bit first, then the status
			if (pend_prim_q) pend_prim_q <= 1'b0;
			else             pend_stat_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/hidden_bit_byte_stream_extractor.sv
// channel | direction | handshake                 | payload
// in      | input     | in_valid / in_ready       | in_data  (data_byte, is_last)
// out     | output    | out_valid / out_ready     | out_data (kind, value, status, last)
// cfg     | input     | cfg_we, no wait           | cfg_wdata (mode)
//
// One byte is taken per cycle while the queue is not full; its first result
// is written into the queue, then registered into the output stage and offered.
// A byte gives at most two transactions (byte or bit, then end status), and the
// output side hands out one per cycle while out_ready is high, the status last.
// A four-entry queue between the scanner and the output stage absorbs output stalls.
// Reset and a mode write clear the window and progress flags at once.
module hidden_bit_byte_stream_extractor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hbbse_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hbbse_pkg::out_item_t out_data
);
	import hbbse_pkg::*;

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t q_head;

	hbbse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	hbbse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	hbbse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
